/* hdl/phcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path heading/curvature profile package
// Fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package phcp_pkg;

    typedef logic [2:0] state_t;

    localparam logic signed [34:0] PI_Q29     = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q29 = 35'sd3373259426;
    localparam logic signed [18:0] PI_Q13     = 19'sd25736;
    localparam logic [23:0]        GAIN_Q24   = 24'd10188014;

    function automatic logic signed [34:0] atan_q29(input logic [4:0] k);
        logic signed [34:0] r;
        begin
            case (k)
                5'd0:    r = 35'sd421657428;
                5'd1:    r = 35'sd248918915;
                5'd2:    r = 35'sd131521918;
                5'd3:    r = 35'sd66762579;
                5'd4:    r = 35'sd33510843;
                5'd5:    r = 35'sd16771758;
                5'd6:    r = 35'sd8387925;
                5'd7:    r = 35'sd4194219;
                5'd8:    r = 35'sd2097141;
                5'd9:    r = 35'sd1048575;
                5'd30:   r = 35'sd0;
                5'd31:   r = 35'sd0;
                default: r = 35'sd1 <<< (5'd29 - k);
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/path_heading_curvature_profile_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path heading, arc length and curvature profile
// Answers each path point one word later with heading, arc length and
// curvature; the final point is answered together with the point before it.
// ----------------------------------------------------------------------------
// One point at a time: a word is taken only while the block is idle. The first
// point of a path is stored, or answered at once if it is also the last. Every
// later point runs a CORDIC vectoring loop of CORDIC_STEPS iterations (skipped
// for a zero step), a bit-serial gain multiply and a finishing step; an inner
// point then adds a set-up step and a restoring division for its curvature.
// Then one or two result words follow, each held until the downstream side
// takes it.
module path_heading_curvature_profile_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,      // reverse_motion
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,       // point_x, point_y, original_heading, original_curvature
    input  logic         s_tlast,       // last_point
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,       // out_x, out_y, heading, arc_length, curvature
    output logic         m_tuser,       // status
    output logic         m_tlast        // last_result
);

    localparam phcp_pkg::state_t S_IDLE = 3'd0;
    localparam phcp_pkg::state_t S_CORD = 3'd1;
    localparam phcp_pkg::state_t S_MUL  = 3'd2;
    localparam phcp_pkg::state_t S_FIN  = 3'd3;
    localparam phcp_pkg::state_t S_PREP = 3'd4;
    localparam phcp_pkg::state_t S_DIV  = 3'd5;
    localparam phcp_pkg::state_t S_EMA  = 3'd6;
    localparam phcp_pkg::state_t S_EMB  = 3'd7;

    phcp_pkg::state_t state_reg;
    logic        rev_reg;
    logic [31:0] held_x_reg, held_y_reg, held_arc_reg, older_arc_reg;
    logic [15:0] held_head_reg, held_curv_reg, older_head_reg;
    logic [1:0]  seen_reg;
    logic [31:0] in_x_reg, in_y_reg;
    logic [15:0] in_oh_reg, in_oc_reg;
    logic        in_last_reg, short_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [34:0] z_reg;
    logic [59:0] acc_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] new_head_reg, curv_reg;
    logic [31:0] new_arc_reg, ds_reg;
    logic [33:0] num_reg;
    logic [31:0] rem_reg;
    logic        pos_reg;

    logic signed [32:0] dx, dy;
    logic signed [35:0] dxe, dye, xs, ys;
    logic signed [59:0] rnd_add;
    logic [59:0] acc_rnd;
    logic [36:0] arc_sum;
    logic signed [34:0] zw;
    logic signed [18:0] hr;
    logic [15:0] head_c;
    logic signed [16:0] dh;
    logic [16:0] dh_abs;
    logic [31:0] ds;
    logic [33:0] mag;
    logic [15:0] curv_sat;
    logic [32:0] r2;
    logic [33:0] r2w;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_EMA) || (state_reg == S_EMB);

    always_comb
    begin
        if (state_reg == S_EMB)
        begin
            m_tdata = {in_oc_reg, new_arc_reg, in_oh_reg, in_y_reg, in_x_reg};
            m_tlast = 1'b1;
        end
        else
        begin
            m_tdata = {curv_reg, held_arc_reg, held_head_reg, held_y_reg, held_x_reg};
            m_tlast = 1'b0;
        end
        m_tuser = short_reg;
    end

    always_comb
    begin
        dx  = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({held_x_reg[31], held_x_reg});
        dy  = $signed({s_tdata[63], s_tdata[63:32]}) - $signed({held_y_reg[31], held_y_reg});
        dxe = {{3{dx[32]}}, dx};
        dye = {{3{dy[32]}}, dy};
        xs  = x_reg >>> cnt_reg[4:0];
        ys  = y_reg >>> cnt_reg[4:0];
        rnd_add = 60'sd8388608;
        acc_rnd = acc_reg + rnd_add;
        arc_sum = {5'd0, held_arc_reg} + {1'b0, acc_rnd[59:24]};

        zw = z_reg;
        if (zw > phcp_pkg::PI_Q29)
            zw = zw - phcp_pkg::TWO_PI_Q29;
        if (zw < -phcp_pkg::PI_Q29)
            zw = zw + phcp_pkg::TWO_PI_Q29;
        if (rev_reg)
        begin
            zw = zw + phcp_pkg::PI_Q29;
            if (zw >= phcp_pkg::PI_Q29)
                zw = zw - phcp_pkg::TWO_PI_Q29;
            if (zw < -phcp_pkg::PI_Q29)
                zw = zw + phcp_pkg::TWO_PI_Q29;
        end
        hr = 19'((zw + 35'sd32768) >>> 16);
        if (hr > phcp_pkg::PI_Q13)
            head_c = phcp_pkg::PI_Q13[15:0];
        else if (hr < -phcp_pkg::PI_Q13)
            head_c = 16'(-phcp_pkg::PI_Q13);
        else
            head_c = hr[15:0];

        dh     = $signed({new_head_reg[15], new_head_reg})
                 - $signed({older_head_reg[15], older_head_reg});
        dh_abs = dh[16] ? 17'(-dh) : 17'(dh);
        ds     = new_arc_reg - older_arc_reg;

        r2  = {rem_reg, num_reg[33]};
        r2w = {1'b0, r2} - {2'b00, ds_reg};

        mag = (state_reg == S_PREP) ? 34'd32768 : num_reg;
        if (pos_reg)
            curv_sat = (mag > 34'd32767) ? 16'h7FFF : mag[15:0];
        else
            curv_sat = (mag > 34'd32768) ? 16'h8000 : 16'(-mag[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rev_reg        <= 1'b0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_arc_reg   <= '0;
            older_arc_reg  <= '0;
            held_head_reg  <= '0;
            held_curv_reg  <= '0;
            older_head_reg <= '0;
            seen_reg       <= '0;
            cnt_reg        <= '0;
            in_x_reg       <= '0;
            in_y_reg       <= '0;
            in_oh_reg      <= '0;
            in_oc_reg      <= '0;
            in_last_reg    <= 1'b0;
            short_reg      <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
            acc_reg        <= '0;
            new_head_reg   <= '0;
            curv_reg       <= '0;
            new_arc_reg    <= '0;
            ds_reg         <= '0;
            num_reg        <= '0;
            rem_reg        <= '0;
            pos_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                rev_reg <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        in_x_reg    <= s_tdata[31:0];
                        in_y_reg    <= s_tdata[63:32];
                        in_oh_reg   <= s_tdata[79:64];
                        in_oc_reg   <= s_tdata[95:80];
                        in_last_reg <= s_tlast;
                        short_reg   <= s_tlast && (seen_reg != 2'd3);
                        cnt_reg     <= '0;
                        acc_reg     <= '0;
                        if (seen_reg == 2'd0)
                        begin
                            new_arc_reg <= '0;
                            if (s_tlast)
                                state_reg <= S_EMB;
                            else
                            begin
                                held_x_reg    <= s_tdata[31:0];
                                held_y_reg    <= s_tdata[63:32];
                                held_head_reg <= s_tdata[79:64];
                                held_curv_reg <= s_tdata[95:80];
                                held_arc_reg  <= '0;
                                older_head_reg <= held_head_reg;
                                older_arc_reg  <= held_arc_reg;
                                seen_reg      <= 2'd1;
                            end
                        end
                        else if (dx == 33'sd0 && dy == 33'sd0)
                        begin
                            x_reg     <= '0;
                            y_reg     <= '0;
                            z_reg     <= '0;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            if (dx < 0)
                            begin
                                x_reg <= -dxe;
                                y_reg <= -dye;
                                z_reg <= (dy >= 0) ? phcp_pkg::PI_Q29 : -phcp_pkg::PI_Q29;
                            end
                            else
                            begin
                                x_reg <= dxe;
                                y_reg <= dye;
                                z_reg <= '0;
                            end
                            state_reg <= S_CORD;
                        end
                    end
                end
                S_CORD:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + phcp_pkg::atan_q29(cnt_reg[4:0]);
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - phcp_pkg::atan_q29(cnt_reg[4:0]);
                    end
                    if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_MUL:
                begin
                    acc_reg <= {acc_reg[58:0], 1'b0}
                               + (phcp_pkg::GAIN_Q24[5'(23 - cnt_reg[4:0])]
                                  ? {25'd0, x_reg[34:0]} : 60'd0);
                    if (cnt_reg == 6'd23)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_FIN:
                begin
                    new_head_reg <= head_c;
                    new_arc_reg  <= (arc_sum > 37'hFFFFFFFF) ? 32'hFFFFFFFF : arc_sum[31:0];
                    curv_reg     <= held_curv_reg;
                    if (seen_reg == 2'd3 && !in_last_reg)
                        state_reg <= S_PREP;
                    else
                        state_reg <= S_EMA;
                end
                S_PREP:
                begin
                    pos_reg <= rev_reg ? dh[16] : !dh[16];
                    ds_reg  <= ds;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    num_reg <= {2'b00, dh_abs[16:0], 15'd0} + {3'b000, ds[31:1]};
                    if (dh == 17'sd0)
                    begin
                        curv_reg  <= '0;
                        state_reg <= S_EMA;
                    end
                    else if (ds == 32'd0)
                    begin
                        curv_reg  <= rev_reg ? (dh[16] ? 16'h7FFF : 16'h8000)
                                             : (dh[16] ? 16'h8000 : 16'h7FFF);
                        state_reg <= S_EMA;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!r2w[33])
                    begin
                        rem_reg <= r2w[31:0];
                        num_reg <= {num_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r2[31:0];
                        num_reg <= {num_reg[32:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd34)
                    begin
                        curv_reg  <= curv_sat;
                        state_reg <= S_EMA;
                    end
                end
                S_EMA:
                begin
                    if (m_tready)
                    begin
                        if (in_last_reg)
                            state_reg <= S_EMB;
                        else
                        begin
                            older_head_reg <= held_head_reg;
                            older_arc_reg  <= held_arc_reg;
                            held_x_reg     <= in_x_reg;
                            held_y_reg     <= in_y_reg;
                            held_head_reg  <= new_head_reg;
                            held_arc_reg   <= new_arc_reg;
                            held_curv_reg  <= in_oc_reg;
                            seen_reg       <= (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                S_EMB:
                begin
                    if (m_tready)
                    begin
                        held_x_reg     <= '0;
                        held_y_reg     <= '0;
                        held_arc_reg   <= '0;
                        older_arc_reg  <= '0;
                        held_head_reg  <= '0;
                        held_curv_reg  <= '0;
                        older_head_reg <= '0;
                        seen_reg       <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
